FILE: hdl/atyi_pkg.sv
// package with types, constants and the atan table for the tilt and yaw integrator
`timescale 1ns / 1ps
`default_nettype none
package atyi_pkg;

    localparam int TabLen  = 24;
    localparam int TabFrac = 20;
    localparam int CordW   = 48;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_z;
        logic        [31:0] tick_ms;
    } atyi_in_t;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [31:0] yaw_angle;
    } atyi_out_t;

    typedef enum logic [0:0] {
        REG_ROLL_TRIM  = 1'b0,
        REG_PITCH_TRIM = 1'b1
    } atyi_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_YAW,
        ST_DIV,
        ST_OUT
    } atyi_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic cordic_init;
        logic cordic_step;
        logic angle_latch;
        logic pass_pitch;
        logic yaw_update;
        logic div_init;
        logic div_step;
        logic result_load;
    } atyi_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sqrt_done;
        logic cordic_done;
        logic div_done;
    } atyi_sts_t;

    function automatic logic signed [CordW-1:0] atan_tab(input logic [4:0] idx);
        logic signed [CordW-1:0] v;
        case (idx)
            5'd0:  v = 48'sd47185920;
            5'd1:  v = 48'sd27855475;
            5'd2:  v = 48'sd14718068;
            5'd3:  v = 48'sd7471121;
            5'd4:  v = 48'sd3750058;
            5'd5:  v = 48'sd1876857;
            5'd6:  v = 48'sd938658;
            5'd7:  v = 48'sd469357;
            5'd8:  v = 48'sd234682;
            5'd9:  v = 48'sd117342;
            5'd10: v = 48'sd58671;
            5'd11: v = 48'sd29335;
            5'd12: v = 48'sd14668;
            5'd13: v = 48'sd7334;
            5'd14: v = 48'sd3667;
            5'd15: v = 48'sd1833;
            5'd16: v = 48'sd917;
            5'd17: v = 48'sd458;
            5'd18: v = 48'sd229;
            5'd19: v = 48'sd115;
            5'd20: v = 48'sd57;
            5'd21: v = 48'sd29;
            5'd22: v = 48'sd14;
            5'd23: v = 48'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/accel_tilt_and_yaw_integrator_core.sv
// top level of the accelerometer tilt and gyro yaw integrator
// usage:
//   in channel: in_item (accel x/y/z, gyro z, tick) with in_valid / in_stall
//   out channel: out_item (roll, pitch, yaw) with out_valid / out_stall
//   cfg channel: cfg_valid / cfg_ready, cfg_index, cfg_data (0 roll trim,
//   1 pitch trim, other indexes ignored); cfg_ready only while idle
// steps per item: load, sqrt and cordic for roll, sqrt and cordic
//   for pitch, yaw update, divide by 1000 and output load;
//   one item at a time through the bit-serial sqrt, shared cordic and
//   the two-step reciprocal divide by 1000
// in_stall is high from acceptance until the result is handed to the
//   output register; the output register holds a finished item while
//   out_stall is high and the next item's work runs behind it
// reset clears the state machine, yaw accumulator and last tick and
//   restores the trims to -74 and 202
`timescale 1ns / 1ps
`default_nettype none
module accel_tilt_and_yaw_integrator_core
    import atyi_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 7
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire atyi_in_t    in_item,
    output logic             out_valid,
    input  wire logic        out_stall,
    output atyi_out_t        out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    logic signed [14:0] roll_trim_reg, pitch_trim_reg;
    atyi_cmd_t cmd;
    atyi_sts_t sts;

    // trims are only taken while no item is being worked on
    assign cfg_ready = !in_stall;

    // trim registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_trim_reg  <= -15'sd74;
            pitch_trim_reg <= 15'sd202;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROLL_TRIM:  roll_trim_reg  <= cfg_data;
                REG_PITCH_TRIM: pitch_trim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    atyi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    atyi_dpath #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS),
        .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .roll_trim  (roll_trim_reg),
        .pitch_trim (pitch_trim_reg),
        .cmd        (cmd),
        .sts        (sts),
        .out_item   (out_item)
    );

    // a new result never lands on a stalled one
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!out_valid || !out_stall))
        else $error("result overwrote stalled item");

    // accepting an item starts the sqrt pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && !cmd.result_load))
        else $error("item accept did not start work");

    // stalled output item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_item))
        else $error("stalled result changed");

endmodule
`default_nettype wire

FILE: hdl/atyi_ctrl.sv
// controller state machine sequencing sqrt, cordic and yaw passes, the divide and the output load
`timescale 1ns / 1ps
`default_nettype none
module atyi_ctrl
    import atyi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output atyi_cmd_t      cmd,
    input  wire atyi_sts_t sts
);

    atyi_state_t state_reg, state_next;
    logic        pitch_reg, pitch_next;
    logic        ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pitch_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pitch_reg  <= pitch_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        pitch_next  = pitch_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd         = '0;
        cmd.pass_pitch = pitch_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    pitch_next = 1'b0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_done)
                begin
                    cmd.cordic_init = 1'b1;
                    state_next      = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (sts.cordic_done)
                begin
                    cmd.angle_latch = 1'b1;
                    if (pitch_reg)
                        state_next = ST_YAW;
                    else
                    begin
                        pitch_next = 1'b1;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_YAW:
            begin
                cmd.yaw_update = 1'b1;
                state_next     = ST_DIV;
            end
            ST_DIV:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.div_init = 1'b0;
                end
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.result_load = 1'b1;
                    ovalid_next     = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_YAW)
            cmd.div_init = 1'b1;
    end

endmodule
`default_nettype wire

FILE: hdl/atyi_dpath.sv
// datapath: shared sqrt and cordic units, yaw accumulator and divide by 1000
`timescale 1ns / 1ps
`default_nettype none
module atyi_dpath
    import atyi_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 7
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire atyi_in_t           in_item,
    input  wire logic signed [14:0] roll_trim,
    input  wire logic signed [14:0] pitch_trim,
    input  wire atyi_cmd_t          cmd,
    output atyi_sts_t               sts,
    output atyi_out_t               out_item
);

    localparam int Shift = TabFrac - ANGLE_FRAC_BITS;
    localparam int IterW = $clog2(CORDIC_ITERATIONS + 1);

    // ceil(2^45 / 125), exact for dividends below 2^38
    localparam logic [38:0] Recip125  = 39'd281474976711;
    // 1000 * 2^31, from here on the yaw output saturates
    localparam logic [63:0] YawSatMag = 64'd2147483648000;

    atyi_in_t smp_reg;

    // sqrt: radicand up to 2^47, root up to 2^24 (one bit per cycle)
    logic [47:0] rem_reg;
    logic [24:0] root_reg;
    logic [4:0]  sq_cnt_reg;
    logic [47:0] rad_reg;

    logic signed [CordW-1:0] x_reg, y_reg, z_reg;
    logic [IterW-1:0]        it_reg;
    logic signed [15:0]      roll_reg, pitch_reg;

    logic signed [63:0] yaw_reg;
    logic [31:0]        last_tick_reg;

    logic [37:0] dmag_reg;
    logic        dbig_reg;
    logic [76:0] dacc_reg;
    logic [1:0]  dcnt_reg;
    logic        dneg_reg;

    atyi_out_t res_reg;

    // radicand for current pass
    logic signed [16:0] sa, sb, snum;
    logic [33:0]        sq;
    always_comb
    begin
        if (cmd.pass_pitch)
        begin
            sa   = 17'(smp_reg.accel_y);
            sb   = 17'(smp_reg.accel_z);
            snum = -17'(smp_reg.accel_x);
        end
        else
        begin
            sa   = 17'(smp_reg.accel_x);
            sb   = 17'(smp_reg.accel_z);
            snum = 17'(smp_reg.accel_y);
        end
        sq = 34'(sa * sa) + 34'(sb * sb);
    end

    // restoring sqrt step
    logic [49:0] trial;
    logic [49:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[47:46]};
        trial  = rem_sh - {23'd0, root_reg, 2'b01};
    end

    // cordic step
    logic signed [CordW-1:0] xs, ys, tv;
    always_comb
    begin
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        tv = atan_tab(5'(it_reg));
    end

    logic signed [CordW-1:0] zr;
    logic signed [CordW-1:0] ang;
    logic signed [CordW-1:0] sum;
    logic signed [15:0]      sat;
    always_comb
    begin
        zr  = z_reg + (CordW'(1) <<< (Shift - 1));
        ang = zr >>> Shift;
        sum = ang + CordW'(cmd.pass_pitch ? pitch_trim : roll_trim);
        if (sum > 48'sd32767)
            sat = 16'sh7fff;
        else if (sum < -48'sd32768)
            sat = -16'sh8000;
        else
            sat = sum[15:0];
    end

    // yaw increment and saturating add
    logic [31:0]        dt;
    logic signed [48:0] inc;
    logic signed [64:0] ysum;
    logic signed [63:0] ynew;
    always_comb
    begin
        dt   = smp_reg.tick_ms - last_tick_reg;
        inc  = 49'(smp_reg.gyro_z) * $signed({17'd0, dt});
        ysum = 65'(yaw_reg) + 65'(inc);
        if (ysum > 65'sh0_7fff_ffff_ffff_ffff)
            ynew = 64'sh7fff_ffff_ffff_ffff;
        else if (ysum < -65'sh0_8000_0000_0000_0000)
            ynew = 64'sh8000_0000_0000_0000;
        else
            ynew = ysum[63:0];
    end

    // magnitude of the new yaw, divided as (n >> 3) / 125
    logic [63:0] ymag;
    always_comb
        ymag = ynew[63] ? 64'(-ynew) : 64'(ynew);

    // reciprocal multiply, low half then high half
    logic [18:0] dpart;
    logic [57:0] dprod;
    logic [76:0] dadd;
    always_comb
    begin
        dpart = dcnt_reg[0] ? dmag_reg[37:19] : dmag_reg[18:0];
        dprod = 58'(dpart) * 58'(Recip125);
        dadd  = dcnt_reg[0] ? {dprod, 19'd0} : 77'(dprod);
    end

    logic [31:0]        dquo;
    logic signed [31:0] ysat;
    always_comb
    begin
        dquo = dacc_reg[76:45];
        if (dbig_reg)
            ysat = dneg_reg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else if (dneg_reg)
            ysat = -$signed(dquo);
        else
            ysat = $signed(dquo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg       <= '0;
            last_tick_reg <= '0;
            sq_cnt_reg    <= '0;
            it_reg        <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            if (cmd.load)
                sq_cnt_reg <= '0;
            if (cmd.cordic_step && !sts.cordic_done)
                it_reg <= it_reg + 1'b1;
            if (cmd.cordic_init)
            begin
                it_reg     <= '0;
                sq_cnt_reg <= '0;
            end
            else if (cmd.sqrt_step)
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
            if (cmd.yaw_update)
            begin
                yaw_reg       <= ynew;
                last_tick_reg <= smp_reg.tick_ms;
            end
            if (cmd.div_init)
                dcnt_reg <= '0;
            else if (cmd.div_step && !sts.div_done)
                dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            smp_reg <= in_item;
        // sqrt of sq * 2^16, 24 result bits, rad loaded on first step
        if (cmd.sqrt_step)
        begin
            if (sq_cnt_reg == 5'd0)
            begin
                rad_reg  <= {sq[31:0], 16'd0};
                rem_reg  <= {46'd0, sq[33:32]};
                root_reg <= '0;
            end
            else
            begin
                rad_reg <= rad_reg << 2;
                if (!trial[49])
                begin
                    rem_reg  <= trial[47:0];
                    root_reg <= {root_reg[23:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh[47:0];
                    root_reg <= {root_reg[23:0], 1'b0};
                end
            end
        end
        if (cmd.cordic_init)
        begin
            x_reg <= CordW'($signed({1'b0, root_reg}));
            y_reg <= CordW'(snum) <<< 8;
            z_reg <= '0;
        end
        else if (cmd.cordic_step && !sts.cordic_done)
        begin
            if (x_reg == '0 && y_reg == '0)
            begin
                z_reg <= '0;
            end
            else if (!y_reg[CordW-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + tv;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - tv;
            end
        end
        if (cmd.angle_latch)
        begin
            if (cmd.pass_pitch)
                pitch_reg <= sat;
            else
                roll_reg <= sat;
        end
        if (cmd.div_init)
        begin
            dneg_reg <= ynew[63];
            dbig_reg <= (ymag >= YawSatMag);
            dmag_reg <= ymag[40:3];
            dacc_reg <= '0;
        end
        else if (cmd.div_step && !sts.div_done)
            dacc_reg <= dacc_reg + dadd;
        if (cmd.result_load)
        begin
            res_reg.roll_angle  <= roll_reg;
            res_reg.pitch_angle <= pitch_reg;
            res_reg.yaw_angle   <= ysat;
        end
    end

    assign sts.sqrt_done   = (sq_cnt_reg == 5'd25);
    assign sts.cordic_done = (it_reg == IterW'(CORDIC_ITERATIONS));
    assign sts.div_done    = (dcnt_reg == 2'd2);
    assign out_item        = res_reg;

endmodule
`default_nettype wire
